// ===== rtl/ple_pkg.sv =====
package ple_pkg;

    localparam int CMD_W           = 3;
    localparam int POS_W           = 8;
    localparam int VAL_W           = 32;
    localparam int STATUS_W        = 2;
    localparam int FOUND_W         = 7;
    localparam int COUNT_W         = 7;
    localparam int DEF_CAPACITY    = 64;
    localparam int DEF_ENTRY_WIDTH = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT   = 3'd0,
        CMD_REMOVE   = 3'd1,
        CMD_REPLACE  = 3'd2,
        CMD_RETRIEVE = 3'd3,
        CMD_SEARCH   = 3'd4,
        CMD_CLEAR    = 3'd5
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_BAD_POS = 2'd1,
        STAT_EMPTY   = 2'd2,
        STAT_FULL    = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_SCAN = 1'b1
    } t_state;

    // What every cell does in the current cycle.
    typedef enum logic [2:0] {
        OP_HOLD         = 3'd0,
        OP_INSERT       = 3'd1,
        OP_REMOVE       = 3'd2,
        OP_WRITE        = 3'd3,
        OP_SEARCH_START = 3'd4,
        OP_SEARCH_STEP  = 3'd5
    } t_cell_op;

    typedef struct packed {
        t_cell_op         op;
        logic [POS_W-1:0] pos;
    } t_cell_ctl;

endpackage

// ===== rtl/positional_list_engine_core.sv =====
// Channel  Direction  Handshake                   Payload
// -------  ---------  --------------------------  ------------------------------------------
// in       request    i_in_valid / o_in_ready     i_command, i_position, i_value_in
// out      result     o_out_valid / i_out_ready   o_status, o_value_out, o_found_position,
//                                                 o_entry_count, o_is_empty
//
// Insert, remove, replace, retrieve, clear and unused codes finish in the accept cycle;
// with the result side taking every cycle they run one request per cycle.
// A search walks a token down the cell chain one cell per cycle: it blocks the request
// side from accept until the token reaches the first matching position or passes the list end.
// Reset (synchronous, active low) clears the count, the search token and output valid;
// cell contents are left as they are and only ever read after being written.
// A pending result that is not taken stalls new requests and a finishing search.
module positional_list_engine_core #(
    parameter int CAPACITY    = ple_pkg::DEF_CAPACITY,
    parameter int ENTRY_WIDTH = ple_pkg::DEF_ENTRY_WIDTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [ple_pkg::CMD_W-1:0]        i_command,
    input  logic [ple_pkg::POS_W-1:0]        i_position,
    input  logic signed [ple_pkg::VAL_W-1:0] i_value_in,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [ple_pkg::STATUS_W-1:0]     o_status,
    output logic signed [ple_pkg::VAL_W-1:0] o_value_out,
    output logic [ple_pkg::FOUND_W-1:0]      o_found_position,
    output logic [ple_pkg::COUNT_W-1:0]      o_entry_count,
    output logic                             o_is_empty
);

    // count holds 0..CAPACITY; compares need room for count + 1 and an 8-bit position
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CNT1_W = $clog2(CAPACITY + 2);
    localparam int CMP_W  = (CNT1_W > ple_pkg::POS_W) ? CNT1_W : ple_pkg::POS_W;

    ple_pkg::t_cell_ctl     w_ctl;
    logic [ENTRY_WIDTH-1:0] w_val;
    logic [ENTRY_WIDTH-1:0] w_data [CAPACITY];
    logic [ENTRY_WIDTH-1:0] w_rd   [CAPACITY];
    logic                   w_tok  [CAPACITY];
    logic                   w_hit  [CAPACITY];
    logic [ENTRY_WIDTH-1:0] w_rd_or;
    logic                   w_hit_or;

    ple_ctrl #(
        .CAPACITY    (CAPACITY),
        .ENTRY_WIDTH (ENTRY_WIDTH),
        .CNT_W       (CNT_W),
        .CMP_W       (CMP_W)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_command        (i_command),
        .i_position       (i_position),
        .i_value_in       (i_value_in),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_value_out      (o_value_out),
        .o_found_position (o_found_position),
        .o_entry_count    (o_entry_count),
        .o_is_empty       (o_is_empty),
        .i_hit            (w_hit_or),
        .i_rd             (w_rd_or),
        .o_ctl            (w_ctl),
        .o_val            (w_val)
    );

    // Cell g holds list position g+1. Insert pulls from the left neighbor,
    // remove from the right; the search token moves one cell right per step.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [ENTRY_WIDTH-1:0] w_prev_data;
        logic [ENTRY_WIDTH-1:0] w_next_data;
        logic                   w_prev_tok;

        if (g == 0) begin : g_head
            assign w_prev_data = w_val;
            assign w_prev_tok  = 1'b0;
        end else begin : g_body
            assign w_prev_data = w_data[g-1];
            assign w_prev_tok  = w_tok[g-1];
        end

        // the tail has no right neighbor; what it pulls on remove lies past the list
        if (g == CAPACITY - 1) begin : g_tail
            assign w_next_data = w_data[g];
        end else begin : g_mid
            assign w_next_data = w_data[g+1];
        end

        ple_cell #(
            .ENTRY_WIDTH (ENTRY_WIDTH),
            .INDEX       (g),
            .CMP_W       (CMP_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_val       (w_val),
            .i_prev_data (w_prev_data),
            .i_next_data (w_next_data),
            .i_prev_tok  (w_prev_tok),
            .o_data      (w_data[g]),
            .o_tok       (w_tok[g]),
            .o_hit       (w_hit[g]),
            .o_rd        (w_rd[g])
        );
    end

    // At most one cell addresses the position and at most one holds the token,
    // so plain OR trees collect the read value and the match flag.
    always_comb begin
        w_rd_or  = '0;
        w_hit_or = 1'b0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_rd_or  = w_rd_or | w_rd[k];
            w_hit_or = w_hit_or | w_hit[k];
        end
    end

endmodule

// ===== rtl/ple_cell.sv =====
module ple_cell #(
    parameter int ENTRY_WIDTH = ple_pkg::DEF_ENTRY_WIDTH,
    parameter int INDEX       = 0,
    parameter int CMP_W       = ple_pkg::POS_W
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  ple_pkg::t_cell_ctl     i_ctl,
    input  logic [ENTRY_WIDTH-1:0] i_val,
    input  logic [ENTRY_WIDTH-1:0] i_prev_data,
    input  logic [ENTRY_WIDTH-1:0] i_next_data,
    input  logic                   i_prev_tok,
    output logic [ENTRY_WIDTH-1:0] o_data,
    output logic                   o_tok,
    output logic                   o_hit,
    output logic [ENTRY_WIDTH-1:0] o_rd
);

    localparam logic [CMP_W-1:0] MY_POS = CMP_W'(INDEX + 1);

    logic [ENTRY_WIDTH-1:0] r_data;
    logic [ENTRY_WIDTH-1:0] n_data;
    logic                   r_tok;
    logic                   n_tok;
    logic [CMP_W-1:0]       w_pos;
    logic                   w_at;
    logic                   w_after;

    assign w_pos   = CMP_W'(i_ctl.pos);
    assign w_at    = (MY_POS == w_pos);
    assign w_after = (MY_POS > w_pos);

    always_comb begin
        n_data = r_data;
        n_tok  = r_tok;
        unique case (i_ctl.op)
            ple_pkg::OP_INSERT: begin
                if (w_after) begin
                    n_data = i_prev_data;
                end else if (w_at) begin
                    n_data = i_val;
                end
            end
            ple_pkg::OP_REMOVE: begin
                if (w_at || w_after) begin
                    n_data = i_next_data;
                end
            end
            ple_pkg::OP_WRITE: begin
                if (w_at) begin
                    n_data = i_val;
                end
            end
            ple_pkg::OP_SEARCH_START: n_tok = (INDEX == 0);
            ple_pkg::OP_SEARCH_STEP:  n_tok = i_prev_tok;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        if (!i_rst_n) begin
            r_tok <= 1'b0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_data = r_data;
    assign o_tok  = r_tok;
    assign o_hit  = r_tok && (r_data == i_val);
    assign o_rd   = w_at ? r_data : '0;

endmodule

// ===== rtl/ple_ctrl.sv =====
module ple_ctrl #(
    parameter int CAPACITY    = ple_pkg::DEF_CAPACITY,
    parameter int ENTRY_WIDTH = ple_pkg::DEF_ENTRY_WIDTH,
    parameter int CNT_W       = $clog2(CAPACITY + 1),
    parameter int CMP_W       = ple_pkg::POS_W
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [ple_pkg::CMD_W-1:0]        i_command,
    input  logic [ple_pkg::POS_W-1:0]        i_position,
    input  logic signed [ple_pkg::VAL_W-1:0] i_value_in,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [ple_pkg::STATUS_W-1:0]     o_status,
    output logic signed [ple_pkg::VAL_W-1:0] o_value_out,
    output logic [ple_pkg::FOUND_W-1:0]      o_found_position,
    output logic [ple_pkg::COUNT_W-1:0]      o_entry_count,
    output logic                             o_is_empty,
    input  logic                             i_hit,
    input  logic [ENTRY_WIDTH-1:0]           i_rd,
    output ple_pkg::t_cell_ctl               o_ctl,
    output logic [ENTRY_WIDTH-1:0]           o_val
);

    ple_pkg::t_state r_state;
    ple_pkg::t_state n_state;

    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       n_count;
    logic [CNT_W-1:0]       r_scan;
    logic [CNT_W-1:0]       n_scan;
    logic [ENTRY_WIDTH-1:0] r_key;
    logic [ENTRY_WIDTH-1:0] n_key;

    logic                             r_out_valid;
    logic [ple_pkg::STATUS_W-1:0]     r_status;
    logic [ple_pkg::VAL_W-1:0]        r_value;
    logic [ple_pkg::FOUND_W-1:0]      r_found;
    logic [ple_pkg::COUNT_W-1:0]      r_ecount;
    logic                             r_empty;

    logic                             w_load;
    ple_pkg::t_status                 w_status;
    logic [ple_pkg::VAL_W-1:0]        w_value;
    logic [ple_pkg::FOUND_W-1:0]      w_found;

    logic                   w_out_free;
    logic                   w_accept;
    logic                   w_done;
    logic [ENTRY_WIDTH-1:0] w_in_val;
    logic [63:0]            w_rd_ext;
    logic [CMP_W-1:0]       w_pos;
    logic [CMP_W-1:0]       w_cnt;
    logic                   w_is_search;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == ple_pkg::S_IDLE) && w_out_free;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_is_search = (i_command == ple_pkg::CMD_SEARCH);
    assign w_in_val    = ENTRY_WIDTH'(64'(i_value_in));
    assign w_rd_ext    = 64'($signed(i_rd));
    assign w_pos       = CMP_W'(i_position);
    assign w_cnt       = CMP_W'(r_count);
    // end of list checked before the token cell's compare
    assign w_done      = (r_scan >= r_count) || i_hit;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ple_pkg::S_IDLE: begin
                if (w_accept && w_is_search) begin
                    n_state = ple_pkg::S_SCAN;
                end
            end
            ple_pkg::S_SCAN: begin
                if (w_done && w_out_free) begin
                    n_state = ple_pkg::S_IDLE;
                end
            end
            default: n_state = ple_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_ctl.op  = ple_pkg::OP_HOLD;
        o_ctl.pos = i_position;
        o_val     = (r_state == ple_pkg::S_SCAN) ? r_key : w_in_val;
        n_count   = r_count;
        n_scan    = r_scan;
        n_key     = r_key;
        w_load    = 1'b0;
        w_status  = ple_pkg::STAT_OK;
        w_value   = '0;
        w_found   = '0;
        if (r_state == ple_pkg::S_IDLE) begin
            if (w_accept) begin
                w_load = 1'b1;
                unique case (ple_pkg::t_cmd'(i_command))
                    ple_pkg::CMD_INSERT: begin
                        if (w_pos == '0 || w_pos > w_cnt + CMP_W'(1)) begin
                            w_status = ple_pkg::STAT_BAD_POS;
                        end else if (r_count == CNT_W'(CAPACITY)) begin
                            w_status = ple_pkg::STAT_FULL;
                        end else begin
                            o_ctl.op = ple_pkg::OP_INSERT;
                            n_count  = r_count + CNT_W'(1);
                        end
                    end
                    ple_pkg::CMD_REMOVE, ple_pkg::CMD_REPLACE,
                    ple_pkg::CMD_RETRIEVE: begin
                        if (r_count == '0) begin
                            w_status = ple_pkg::STAT_EMPTY;
                        end else if (w_pos == '0 || w_pos > w_cnt) begin
                            w_status = ple_pkg::STAT_BAD_POS;
                        end else if (i_command == ple_pkg::CMD_REMOVE) begin
                            o_ctl.op = ple_pkg::OP_REMOVE;
                            w_value  = w_rd_ext[ple_pkg::VAL_W-1:0];
                            n_count  = r_count - CNT_W'(1);
                        end else if (i_command == ple_pkg::CMD_REPLACE) begin
                            o_ctl.op = ple_pkg::OP_WRITE;
                        end else begin
                            w_value = w_rd_ext[ple_pkg::VAL_W-1:0];
                        end
                    end
                    ple_pkg::CMD_SEARCH: begin
                        w_load   = 1'b0;
                        o_ctl.op = ple_pkg::OP_SEARCH_START;
                        n_scan   = '0;
                        n_key    = w_in_val;
                    end
                    ple_pkg::CMD_CLEAR: n_count = '0;
                    default: begin
                    end
                endcase
            end
        end else begin
            if (!w_done) begin
                o_ctl.op = ple_pkg::OP_SEARCH_STEP;
                n_scan   = r_scan + CNT_W'(1);
            end else if (w_out_free) begin
                w_load = 1'b1;
                if (r_scan < r_count) begin
                    w_found = ple_pkg::FOUND_W'(r_scan) + ple_pkg::FOUND_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_scan <= n_scan;
        if (w_load) begin
            r_status <= w_status;
            r_value  <= w_value;
            r_found  <= w_found;
            r_ecount <= ple_pkg::COUNT_W'(n_count);
            r_empty  <= (n_count == '0);
        end
        if (!i_rst_n) begin
            r_state     <= ple_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_value_out      = r_value;
    assign o_found_position = r_found;
    assign o_entry_count    = r_ecount;
    assign o_is_empty       = r_empty;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ple_pkg::S_SCAN) |-> (r_scan <= r_count))
        else $error("scan index past end of list");

    a_plain_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_is_search) |=> (r_out_valid && r_state == ple_pkg::S_IDLE))
        else $error("result missing after non-search request");

    a_scan_count_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ple_pkg::S_SCAN) |=> $stable(r_count))
        else $error("list length changed during search");

endmodule
